@@ src/bst_pkg.sv @@
// Shared types and constants for the bencode stream tokenizer.
// Holds the phase, frame and event codes and the state and result structs.
// Has no dependencies; every other file of the block uses it.
package bst_pkg;

  localparam int unsigned BYTE_W        = 8;
  localparam int unsigned VALUE_W       = 63;
  localparam int unsigned DEPTH_W       = 6;
  localparam int unsigned EVENT_W       = 3;
  localparam int unsigned MAX_DEPTH_DEF = 32;

  localparam logic [BYTE_W-1:0] CH_I     = 8'h69;
  localparam logic [BYTE_W-1:0] CH_E     = 8'h65;
  localparam logic [BYTE_W-1:0] CH_L     = 8'h6C;
  localparam logic [BYTE_W-1:0] CH_D     = 8'h64;
  localparam logic [BYTE_W-1:0] CH_COLON = 8'h3A;
  localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;

  typedef enum logic [1:0] {
    PH_VALUE = 2'd0,
    PH_INT   = 2'd1,
    PH_LEN   = 2'd2,
    PH_DATA  = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    FR_LIST = 2'd0,
    FR_KEY  = 2'd1,
    FR_VAL  = 2'd2,
    FR_NONE = 2'd3
  } frame_e;

  typedef enum logic [EVENT_W-1:0] {
    EV_NONE  = 3'd0,
    EV_INT   = 3'd1,
    EV_HDR   = 3'd2,
    EV_BYTE  = 3'd3,
    EV_LIST  = 3'd4,
    EV_DICT  = 3'd5,
    EV_CLOSE = 3'd6,
    EV_ERR   = 3'd7
  } event_e;

  typedef struct packed {
    phase_e               phase;
    logic [VALUE_W-1:0]   accum;
    logic [VALUE_W-1:0]   left;
  } state_t;

  typedef struct packed {
    event_e               event_res;
    logic [VALUE_W-1:0]   value;
    logic                 is_key;
    logic [DEPTH_W-1:0]   depth;
    logic                 last_byte;
    logic                 doc_done;
  } result_t;

endpackage

@@ src/bst_if.sv @@
// Handshake channels of the bencode stream tokenizer: byte input and token output.
// Each carries valid, ready and the item payload, with source and sink modports.
// Depends on bst_pkg for the field widths.
interface bst_byte_if;
  logic                           valid;
  logic                           ready;
  logic [bst_pkg::BYTE_W-1:0]     in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

interface bst_token_if;
  logic                           valid;
  logic                           ready;
  logic [bst_pkg::EVENT_W-1:0]    event_res;
  logic [bst_pkg::VALUE_W-1:0]    value;
  logic                           is_key;
  logic [bst_pkg::DEPTH_W-1:0]    depth;
  logic                           last_byte;
  logic                           doc_done;

  modport source (output valid, output event_res, output value, output is_key,
                  output depth, output last_byte, output doc_done, input ready);
  modport sink (input valid, input event_res, input value, input is_key,
                input depth, input last_byte, input doc_done, output ready);
endinterface

@@ src/bst_frame_stack.sv @@
// Frame stack memory: one write port and two registered read ports.
// The read ports hold the top frame and the frame below it, with write forwarding.
// Depends on bst_pkg for the default depth.
module bst_frame_stack #(
  parameter int unsigned DEPTH = bst_pkg::MAX_DEPTH_DEF,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic          we_i,
  input  logic [AW-1:0] wa_i,
  input  logic [1:0]    wd_i,
  input  logic [AW-1:0] ra_top_i,
  input  logic [AW-1:0] ra_below_i,
  output logic [1:0]    top_o,
  output logic [1:0]    below_o
);

  logic [1:0] mem [DEPTH];
  logic [1:0] top_q;
  logic [1:0] below_q;

  always_ff @(posedge clk_i) begin
    if (en_i && we_i) begin
      mem[wa_i] <= wd_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      top_q   <= (we_i && (wa_i == ra_top_i)) ? wd_i : mem[ra_top_i];
      below_q <= (we_i && (wa_i == ra_below_i)) ? wd_i : mem[ra_below_i];
    end
  end

  assign top_o   = top_q;
  assign below_o = below_q;

endmodule

@@ src/bst_step.sv @@
// Per-byte tokenizer logic: decodes one byte against the current state.
// Produces the token, the next state and the frame stack write.
// Depends on bst_pkg for codes, character constants and structs.
module bst_step #(
  parameter int unsigned MAX_DEPTH = bst_pkg::MAX_DEPTH_DEF,
  parameter int unsigned LVL_W     = $clog2(MAX_DEPTH + 1),
  parameter int unsigned AW        = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1
) (
  input  logic [bst_pkg::BYTE_W-1:0] byte_i,
  input  bst_pkg::state_t            state_i,
  input  logic [LVL_W-1:0]           level_i,
  input  logic [1:0]                 top_i,
  input  logic [1:0]                 below_i,
  output bst_pkg::state_t            state_o,
  output logic [LVL_W-1:0]           level_o,
  output logic                       we_o,
  output logic [AW-1:0]              wa_o,
  output logic [1:0]                 wd_o,
  output bst_pkg::result_t           result_o
);

  logic                            is_digit;
  logic [3:0]                      digit_val;
  logic [bst_pkg::VALUE_W+3:0]     accum_x;
  logic                            accum_ovf;
  logic [bst_pkg::VALUE_W-1:0]     left_dec;
  bst_pkg::frame_e                 cur_t;
  bst_pkg::frame_e                 fin_t;
  logic [AW-1:0]                   fin_idx;
  logic                            do_fin;
  logic                            err;
  logic [LVL_W-1:0]                level_m1;

  assign is_digit  = (byte_i >= bst_pkg::CH_ZERO) && (byte_i <= bst_pkg::CH_NINE);
  assign digit_val = byte_i[3:0];
  assign accum_x   = ({4'b0, state_i.accum} << 3) + ({4'b0, state_i.accum} << 1)
                   + (bst_pkg::VALUE_W + 4)'(digit_val);
  assign accum_ovf = |accum_x[bst_pkg::VALUE_W+3:bst_pkg::VALUE_W];
  assign left_dec  = (state_i.left != '0) ? state_i.left - 1'b1 : state_i.left;
  assign level_m1  = level_i - LVL_W'(1);
  assign cur_t     = (level_i == '0) ? bst_pkg::FR_NONE : bst_pkg::frame_e'(top_i);

  always_comb begin
    state_o  = state_i;
    level_o  = level_i;
    we_o     = 1'b0;
    wa_o     = AW'(level_m1);
    wd_o     = bst_pkg::FR_LIST;
    do_fin   = 1'b0;
    fin_t    = cur_t;
    fin_idx  = AW'(level_m1);
    err      = 1'b0;
    result_o = '0;
    result_o.event_res = bst_pkg::EV_NONE;

    case (state_i.phase)
      bst_pkg::PH_VALUE: begin
        if ((byte_i == bst_pkg::CH_E) &&
            ((cur_t == bst_pkg::FR_LIST) || (cur_t == bst_pkg::FR_KEY))) begin
          level_o = level_m1;
          result_o.event_res = bst_pkg::EV_CLOSE;
          do_fin  = 1'b1;
          fin_t   = (level_i == LVL_W'(1)) ? bst_pkg::FR_NONE : bst_pkg::frame_e'(below_i);
          fin_idx = AW'(level_i - LVL_W'(2));
        end else if (is_digit) begin
          state_o.accum = bst_pkg::VALUE_W'(digit_val);
          state_o.phase = bst_pkg::PH_LEN;
        end else if (byte_i == bst_pkg::CH_COLON) begin
          result_o.event_res = bst_pkg::EV_HDR;
          result_o.is_key    = (cur_t == bst_pkg::FR_KEY);
          result_o.last_byte = 1'b1;
          do_fin = 1'b1;
        end else if (cur_t == bst_pkg::FR_KEY) begin
          err = 1'b1;
        end else if (byte_i == bst_pkg::CH_I) begin
          state_o.accum = '0;
          state_o.phase = bst_pkg::PH_INT;
        end else if ((byte_i == bst_pkg::CH_L) || (byte_i == bst_pkg::CH_D)) begin
          if (level_i >= LVL_W'(MAX_DEPTH)) begin
            err = 1'b1;
          end else begin
            we_o    = 1'b1;
            wa_o    = AW'(level_i);
            wd_o    = (byte_i == bst_pkg::CH_L) ? bst_pkg::FR_LIST : bst_pkg::FR_KEY;
            level_o = level_i + LVL_W'(1);
            result_o.event_res = (byte_i == bst_pkg::CH_L) ? bst_pkg::EV_LIST
                                                           : bst_pkg::EV_DICT;
          end
        end else begin
          err = 1'b1;
        end
      end
      bst_pkg::PH_INT: begin
        if (is_digit) begin
          if (accum_ovf) begin
            err = 1'b1;
          end else begin
            state_o.accum = accum_x[bst_pkg::VALUE_W-1:0];
          end
        end else if (byte_i == bst_pkg::CH_E) begin
          result_o.event_res = bst_pkg::EV_INT;
          result_o.value     = state_i.accum;
          state_o.accum      = '0;
          do_fin = 1'b1;
        end else begin
          err = 1'b1;
        end
      end
      bst_pkg::PH_LEN: begin
        if (is_digit) begin
          if (accum_ovf) begin
            err = 1'b1;
          end else begin
            state_o.accum = accum_x[bst_pkg::VALUE_W-1:0];
          end
        end else if (byte_i == bst_pkg::CH_COLON) begin
          result_o.event_res = bst_pkg::EV_HDR;
          result_o.value     = state_i.accum;
          result_o.is_key    = (cur_t == bst_pkg::FR_KEY);
          state_o.accum      = '0;
          if (state_i.accum == '0) begin
            result_o.last_byte = 1'b1;
            do_fin = 1'b1;
          end else begin
            state_o.left  = state_i.accum;
            state_o.phase = bst_pkg::PH_DATA;
          end
        end else begin
          err = 1'b1;
        end
      end
      bst_pkg::PH_DATA: begin
        result_o.event_res = bst_pkg::EV_BYTE;
        result_o.value     = bst_pkg::VALUE_W'(byte_i);
        result_o.is_key    = (cur_t == bst_pkg::FR_KEY);
        state_o.left       = left_dec;
        if (left_dec == '0) begin
          result_o.last_byte = 1'b1;
          do_fin = 1'b1;
        end
      end
      default: begin
        err = 1'b1;
      end
    endcase

    if (do_fin) begin
      state_o.phase = bst_pkg::PH_VALUE;
      case (fin_t)
        bst_pkg::FR_NONE: begin
          result_o.doc_done = 1'b1;
        end
        bst_pkg::FR_KEY: begin
          we_o = 1'b1;
          wa_o = fin_idx;
          wd_o = bst_pkg::FR_VAL;
        end
        bst_pkg::FR_VAL: begin
          we_o = 1'b1;
          wa_o = fin_idx;
          wd_o = bst_pkg::FR_KEY;
        end
        default: begin
        end
      endcase
    end

    if (err) begin
      level_o  = '0;
      state_o  = '0;
      state_o.phase = bst_pkg::PH_VALUE;
      we_o     = 1'b0;
      result_o = '0;
      result_o.event_res = bst_pkg::EV_ERR;
    end

    result_o.depth = bst_pkg::DEPTH_W'(level_o);
  end

endmodule

@@ src/bencode_stream_tokenizer.sv @@
// Top level of the bencode stream tokenizer.
// Instantiates bst_step and bst_frame_stack; uses bst_pkg and the bst_if channels.
//
// Usage: bencoded bytes enter on byte_i, one byte per item. For every byte
// exactly one token item leaves on token_o: none, integer done, string header,
// string byte, list open, dict open, close or error, with value, key flag,
// nesting depth after the byte, last-byte flag and end-of-document flag.
// An accepted byte waits in the input register, is decoded from there, and
// its token is shown from the result register. Throughput is one byte per
// cycle while token_o does not stall, set by the parse state and the frame
// stack memory being updated as each byte is decoded; the memory's two read
// ports keep the top frame and the frame below it ready for the next byte.
// When token_o stalls, the result register holds its token and the input
// register still takes one more byte; byte_i.ready then falls until the
// token is taken. Reset clears the valid flags, the phase, the counters and
// the nesting level; the frame stack needs no clearing pass, since only
// frames below the current level are read.
module bencode_stream_tokenizer #(
  parameter int unsigned MAX_DEPTH = bst_pkg::MAX_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  bst_byte_if.sink    byte_i,
  bst_token_if.source token_o
);

  localparam int unsigned LVL_W = $clog2(MAX_DEPTH + 1);
  localparam int unsigned AW    = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

  logic                          in_valid_q;
  logic [bst_pkg::BYTE_W-1:0]    in_byte_q;
  logic                          out_valid_q;
  bst_pkg::result_t              out_q;
  bst_pkg::result_t              res_d;
  bst_pkg::state_t               state_q;
  bst_pkg::state_t               state_d;
  logic [LVL_W-1:0]              level_q;
  logic [LVL_W-1:0]              level_d;
  logic                          advance;
  logic                          we;
  logic [AW-1:0]                 wa;
  logic [1:0]                    wd;
  logic [1:0]                    top_frame;
  logic [1:0]                    below_frame;

  assign advance      = in_valid_q && (!out_valid_q || token_o.ready);
  assign byte_i.ready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (byte_i.ready) begin
      in_valid_q <= byte_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (byte_i.ready && byte_i.valid) begin
      in_byte_q <= byte_i.in_byte;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= '{phase: bst_pkg::PH_VALUE, accum: '0, left: '0};
      level_q     <= '0;
      out_valid_q <= 1'b0;
    end else if (advance) begin
      state_q     <= state_d;
      level_q     <= level_d;
      out_valid_q <= 1'b1;
    end else if (token_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= res_d;
    end
  end

  bst_step #(
    .MAX_DEPTH (MAX_DEPTH),
    .LVL_W     (LVL_W),
    .AW        (AW)
  ) u_step (
    .byte_i   (in_byte_q),
    .state_i  (state_q),
    .level_i  (level_q),
    .top_i    (top_frame),
    .below_i  (below_frame),
    .state_o  (state_d),
    .level_o  (level_d),
    .we_o     (we),
    .wa_o     (wa),
    .wd_o     (wd),
    .result_o (res_d)
  );

  bst_frame_stack #(
    .DEPTH (MAX_DEPTH),
    .AW    (AW)
  ) u_frame_stack (
    .clk_i      (clk_i),
    .en_i       (advance),
    .we_i       (we),
    .wa_i       (wa),
    .wd_i       (wd),
    .ra_top_i   (AW'(level_d - LVL_W'(1))),
    .ra_below_i (AW'(level_d - LVL_W'(2))),
    .top_o      (top_frame),
    .below_o    (below_frame)
  );

  assign token_o.valid     = out_valid_q;
  assign token_o.event_res = out_q.event_res;
  assign token_o.value     = out_q.value;
  assign token_o.is_key    = out_q.is_key;
  assign token_o.depth     = out_q.depth;
  assign token_o.last_byte = out_q.last_byte;
  assign token_o.doc_done  = out_q.doc_done;

endmodule

@@ src/bst_checker.sv @@
// Port-level checks for the bencode stream tokenizer, bound to the top level.
// Watches the token channel over time; depends on bst_pkg for the event codes.
module bst_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [bst_pkg::EVENT_W-1:0] event_res,
  input logic [bst_pkg::VALUE_W-1:0] value,
  input logic                        is_key,
  input logic [bst_pkg::DEPTH_W-1:0] depth,
  input logic                        last_byte,
  input logic                        doc_done
);

  a_valid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid)
    else $error("Token item dropped while stalled.");

  a_error_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && (event_res == bst_pkg::EV_ERR) |->
      (depth == '0) && (value == '0) && !is_key && !last_byte && !doc_done)
    else $error("Error item carries stale fields.");

  a_done_at_top: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && doc_done |->
      (depth == '0) && ((event_res == bst_pkg::EV_INT) || (event_res == bst_pkg::EV_HDR) ||
                        (event_res == bst_pkg::EV_BYTE) || (event_res == bst_pkg::EV_CLOSE)))
    else $error("Document end flagged inside a container or on a non-value event.");

  a_last_on_string: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && last_byte |->
      ((event_res == bst_pkg::EV_HDR) || (event_res == bst_pkg::EV_BYTE)))
    else $error("Last-byte flag outside a string.");

  a_key_on_string: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && is_key |->
      ((event_res == bst_pkg::EV_HDR) || (event_res == bst_pkg::EV_BYTE)) && (depth != '0))
    else $error("Key flag outside a string inside a dictionary.");

endmodule

bind bencode_stream_tokenizer bst_checker u_bst_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .out_valid (token_o.valid),
  .out_ready (token_o.ready),
  .event_res (token_o.event_res),
  .value     (token_o.value),
  .is_key    (token_o.is_key),
  .depth     (token_o.depth),
  .last_byte (token_o.last_byte),
  .doc_done  (token_o.doc_done)
);
